// ===== sv/mnke_pkg.sv =====
package mnke_pkg;

    // Owner table and note map sizes.
    localparam int KEY_TABLE_DEPTH = 128;
    localparam int KEY_IDX_W       = $clog2(KEY_TABLE_DEPTH);
    localparam int NOTE_COUNT      = 88;
    localparam int NOTE_IDX_W      = $clog2(NOTE_COUNT);

    localparam int NOTE_W     = 7;
    localparam int VEL_W      = 7;
    localparam int KEY_CODE_W = 7;
    localparam int LEVEL_W    = 5;

    localparam logic [NOTE_W-1:0] NOTE_LOW  = 7'd21;
    localparam logic [NOTE_W-1:0] NOTE_HIGH = 7'd108;

    // Command queue between the front and the back; the depth is a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_IDX_W = $clog2(QUEUE_DEPTH);

    typedef logic [1:0] mod_t;
    localparam mod_t MDF_NONE  = 2'd0;
    localparam mod_t MDF_SHIFT = 2'd1;
    localparam mod_t MDF_CTRL  = 2'd2;

    localparam logic [KEY_CODE_W-1:0] KC_SHIFT = 7'd42;
    localparam logic [KEY_CODE_W-1:0] KC_CTRL  = 7'd29;
    localparam logic [KEY_CODE_W-1:0] KC_ALT   = 7'd56;
    localparam logic [KEY_CODE_W-1:0] KC_NONE  = 7'd0;

    // Slots of the event schedule, in the order they go out.
    localparam int EVENT_COUNT = 13;
    localparam int EV_IDX_W    = $clog2(EVENT_COUNT);
    typedef logic [EV_IDX_W-1:0] ev_idx_t;
    localparam ev_idx_t EV_ALT_PRESS  = 4'd0;
    localparam ev_idx_t EV_VK_PRESS   = 4'd1;
    localparam ev_idx_t EV_TAP_SYNC0  = 4'd2;
    localparam ev_idx_t EV_VK_REL     = 4'd3;
    localparam ev_idx_t EV_ALT_REL    = 4'd4;
    localparam ev_idx_t EV_TAP_SYNC1  = 4'd5;
    localparam ev_idx_t EV_KEY_REL    = 4'd6;
    localparam ev_idx_t EV_REL_SYNC   = 4'd7;
    localparam ev_idx_t EV_MOD_PRESS  = 4'd8;
    localparam ev_idx_t EV_KEY_PRESS  = 4'd9;
    localparam ev_idx_t EV_PRESS_SYNC = 4'd10;
    localparam ev_idx_t EV_MOD_REL    = 4'd11;
    localparam ev_idx_t EV_MOD_SYNC   = 4'd12;

    typedef struct packed {
        logic                  on;
        logic [NOTE_W-1:0]     note;
        logic [KEY_CODE_W-1:0] key_code;
        mod_t                  modifier;
        logic                  tap;
        logic [KEY_CODE_W-1:0] level_key;
    } cmd_t;

    localparam logic [KEY_CODE_W-1:0] NOTE_CODE [NOTE_COUNT] = '{
        7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,  7'd10, 7'd11,
        7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd2,  7'd2,  7'd3,  7'd3,  7'd4,
        7'd5,  7'd5,  7'd6,  7'd6,  7'd7,  7'd7,  7'd8,  7'd9,  7'd9,  7'd10,
        7'd10, 7'd11, 7'd16, 7'd16, 7'd17, 7'd17, 7'd18, 7'd18, 7'd19, 7'd20,
        7'd20, 7'd21, 7'd21, 7'd22, 7'd23, 7'd23, 7'd24, 7'd24, 7'd25, 7'd25,
        7'd30, 7'd31, 7'd31, 7'd32, 7'd32, 7'd33, 7'd34, 7'd34, 7'd35, 7'd35,
        7'd36, 7'd36, 7'd37, 7'd38, 7'd38, 7'd44, 7'd44, 7'd45, 7'd46, 7'd46,
        7'd47, 7'd47, 7'd48, 7'd48, 7'd49, 7'd50, 7'd21, 7'd22, 7'd23, 7'd24,
        7'd25, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36
    };

    localparam mod_t NOTE_MOD [NOTE_COUNT] = '{
        MDF_CTRL,  MDF_CTRL,  MDF_CTRL,  MDF_CTRL,  MDF_CTRL,
        MDF_CTRL,  MDF_CTRL,  MDF_CTRL,  MDF_CTRL,  MDF_CTRL,
        MDF_CTRL,  MDF_CTRL,  MDF_CTRL,  MDF_CTRL,  MDF_CTRL,
        MDF_NONE,  MDF_SHIFT, MDF_NONE,  MDF_SHIFT, MDF_NONE,
        MDF_NONE,  MDF_SHIFT, MDF_NONE,  MDF_SHIFT, MDF_NONE,
        MDF_SHIFT, MDF_NONE,  MDF_NONE,  MDF_SHIFT, MDF_NONE,
        MDF_SHIFT, MDF_NONE,  MDF_NONE,  MDF_SHIFT, MDF_NONE,
        MDF_SHIFT, MDF_NONE,  MDF_SHIFT, MDF_NONE,  MDF_NONE,
        MDF_SHIFT, MDF_NONE,  MDF_SHIFT, MDF_NONE,  MDF_NONE,
        MDF_SHIFT, MDF_NONE,  MDF_SHIFT, MDF_NONE,  MDF_SHIFT,
        MDF_NONE,  MDF_NONE,  MDF_SHIFT, MDF_NONE,  MDF_SHIFT,
        MDF_NONE,  MDF_NONE,  MDF_SHIFT, MDF_NONE,  MDF_SHIFT,
        MDF_NONE,  MDF_SHIFT, MDF_NONE,  MDF_NONE,  MDF_SHIFT,
        MDF_NONE,  MDF_SHIFT, MDF_NONE,  MDF_NONE,  MDF_SHIFT,
        MDF_NONE,  MDF_SHIFT, MDF_NONE,  MDF_SHIFT, MDF_NONE,
        MDF_NONE,
        MDF_CTRL,  MDF_CTRL,  MDF_CTRL,  MDF_CTRL,  MDF_CTRL,
        MDF_CTRL,  MDF_CTRL,  MDF_CTRL,  MDF_CTRL,  MDF_CTRL,
        MDF_CTRL,  MDF_CTRL
    };

    localparam logic [KEY_CODE_W-1:0] LEVEL_KEY [2**LEVEL_W] = '{
        7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,  7'd10, 7'd11,
        7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
        7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38,
        7'd44, 7'd45, 7'd46
    };

endpackage

// ===== sv/midi_note_to_key_events_unit.sv =====
// Converts MIDI note on/off items into a stream of key events (type, code, value),
// with m_last marking the final event of each item. Notes outside 21..108 and
// note-offs for keys not held by that note produce no events. The front takes
// one item per cycle, while the queue has room, into a four-entry command
// queue; the back then pops a command, does the owner-table lookup and update,
// and emits its events, 0 to 13 per item, popping the next command only after
// the last event of the current one is loaded. The owner table is a 128-entry
// RAM whose entries read as free until first written, so the block is ready
// right after reset.
module midi_note_to_key_events_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_func,
    input  logic [mnke_pkg::NOTE_W-1:0]     s_note,
    input  logic [mnke_pkg::VEL_W-1:0]      s_velocity,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_event_type,
    output logic [mnke_pkg::KEY_CODE_W-1:0] m_key_code,
    output logic                            m_key_value,
    output logic                            m_last
);

    logic           push_valid;
    logic           push_ready;
    mnke_pkg::cmd_t push_cmd;
    logic           pop_valid;
    logic           pop_ready;
    mnke_pkg::cmd_t pop_cmd;

    mnke_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_func     (s_func),
        .s_note     (s_note),
        .s_velocity (s_velocity),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    mnke_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    mnke_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_cmd      (pop_cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_type (m_event_type),
        .m_key_code   (m_key_code),
        .m_key_value  (m_key_value),
        .m_last       (m_last)
    );

endmodule

// ===== sv/mnke_ram.sv =====
module mnke_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/mnke_front.sv =====
module mnke_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_func,
    input  logic [mnke_pkg::NOTE_W-1:0]    s_note,
    input  logic [mnke_pkg::VEL_W-1:0]     s_velocity,
    output logic                           push_valid,
    input  logic                           push_ready,
    output mnke_pkg::cmd_t                 push_cmd
);

    logic                            in_range;
    logic                            accept;
    logic [mnke_pkg::NOTE_IDX_W-1:0] rom_idx;
    logic [mnke_pkg::NOTE_W-1:0]     note_ofs;
    logic [mnke_pkg::LEVEL_W-1:0]    level;
    logic                            tap;
    logic [mnke_pkg::LEVEL_W-1:0]    level_reg;
    logic                            level_valid_reg;

    assign s_ready  = push_ready;
    assign accept   = s_valid && s_ready;
    assign in_range = (s_note >= mnke_pkg::NOTE_LOW) && (s_note <= mnke_pkg::NOTE_HIGH);
    assign note_ofs = s_note - mnke_pkg::NOTE_LOW;
    assign rom_idx  = note_ofs[mnke_pkg::NOTE_IDX_W-1:0];

    // The level is velocity / 4; a 7-bit velocity never exceeds the top level.
    assign level = s_velocity[mnke_pkg::VEL_W-1:2];
    assign tap   = s_func && (s_velocity != '0)
                   && (!level_valid_reg || (level != level_reg));

    // Out-of-range notes are taken and dropped here.
    assign push_valid = s_valid && in_range;

    always_comb begin
        push_cmd.on        = s_func;
        push_cmd.note      = s_note;
        push_cmd.key_code  = mnke_pkg::NOTE_CODE[rom_idx];
        push_cmd.modifier  = mnke_pkg::NOTE_MOD[rom_idx];
        push_cmd.tap       = tap;
        push_cmd.level_key = mnke_pkg::LEVEL_KEY[level];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            level_reg       <= '0;
            level_valid_reg <= 1'b0;
        end else if (accept && in_range && tap) begin
            level_reg       <= level;
            level_valid_reg <= 1'b1;
        end
    end

endmodule

// ===== sv/mnke_fifo.sv =====
module mnke_fifo (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push_valid,
    output logic           push_ready,
    input  mnke_pkg::cmd_t push_cmd,
    output logic           pop_valid,
    input  logic           pop_ready,
    output mnke_pkg::cmd_t pop_cmd
);

    mnke_pkg::cmd_t                   entry_reg [mnke_pkg::QUEUE_DEPTH];
    logic [mnke_pkg::QUEUE_IDX_W-1:0] wr_ptr_reg;
    logic [mnke_pkg::QUEUE_IDX_W-1:0] rd_ptr_reg;
    logic [mnke_pkg::QUEUE_IDX_W:0]   count_reg;
    logic                             do_push;
    logic                             do_pop;

    assign push_ready = (count_reg != (mnke_pkg::QUEUE_IDX_W+1)'(mnke_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== sv/mnke_back.sv =====
module mnke_back (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            pop_valid,
    output logic                            pop_ready,
    input  mnke_pkg::cmd_t                  pop_cmd,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic                            m_event_type,
    output logic [mnke_pkg::KEY_CODE_W-1:0] m_key_code,
    output logic                            m_key_value,
    output logic                            m_last
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LOOKUP = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    mnke_pkg::cmd_t                      cmd_reg;
    logic [mnke_pkg::EVENT_COUNT-1:0]    mask_reg;
    logic [mnke_pkg::EVENT_COUNT-1:0]    mask_next;
    logic [mnke_pkg::EVENT_COUNT-1:0]    mask_new;
    logic [mnke_pkg::EVENT_COUNT-1:0]    mask_rest;
    logic [mnke_pkg::KEY_TABLE_DEPTH-1:0] owner_valid_reg;
    logic                                owner_valid_q_reg;

    logic                                ram_we;
    logic [mnke_pkg::KEY_IDX_W-1:0]      ram_waddr;
    logic [mnke_pkg::NOTE_W-1:0]         ram_wdata;
    logic                                ram_re;
    logic [mnke_pkg::KEY_IDX_W-1:0]      ram_raddr;
    logic [mnke_pkg::NOTE_W-1:0]         ram_rdata;

    logic [mnke_pkg::NOTE_W-1:0]         owner;
    logic                                in_table;
    logic                                release_key;
    logic                                press_key;
    logic                                has_mod;
    logic [mnke_pkg::KEY_CODE_W-1:0]     mod_key;
    mnke_pkg::ev_idx_t                   ev_idx;
    logic                                ev_type;
    logic [mnke_pkg::KEY_CODE_W-1:0]     ev_code;
    logic                                ev_value;
    logic                                out_load;

    logic                                m_valid_reg;
    logic                                m_event_type_reg;
    logic [mnke_pkg::KEY_CODE_W-1:0]     m_key_code_reg;
    logic                                m_key_value_reg;
    logic                                m_last_reg;

    mnke_ram #(
        .WIDTH(mnke_pkg::NOTE_W),
        .DEPTH(mnke_pkg::KEY_TABLE_DEPTH)
    ) u_owner_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign pop_ready = (state_reg == ST_IDLE);
    assign ram_re    = pop_valid && pop_ready;
    assign ram_raddr = pop_cmd.key_code[mnke_pkg::KEY_IDX_W-1:0];

    // A key whose entry was never written since reset is free.
    assign owner    = owner_valid_q_reg ? ram_rdata : '0;
    assign in_table = ({1'b0, cmd_reg.key_code}
                       < (mnke_pkg::KEY_CODE_W+1)'(mnke_pkg::KEY_TABLE_DEPTH));
    assign has_mod  = (cmd_reg.modifier != mnke_pkg::MDF_NONE);
    assign mod_key  = (cmd_reg.modifier == mnke_pkg::MDF_SHIFT) ? mnke_pkg::KC_SHIFT
                                                                : mnke_pkg::KC_CTRL;
    assign press_key   = cmd_reg.on && in_table;
    assign release_key = in_table && (cmd_reg.on ? ((owner != '0) && (owner != cmd_reg.note))
                                                 : (owner == cmd_reg.note));

    always_comb begin
        mask_new = '0;
        mask_new[mnke_pkg::EV_ALT_PRESS]  = cmd_reg.tap;
        mask_new[mnke_pkg::EV_VK_PRESS]   = cmd_reg.tap;
        mask_new[mnke_pkg::EV_TAP_SYNC0]  = cmd_reg.tap;
        mask_new[mnke_pkg::EV_VK_REL]     = cmd_reg.tap;
        mask_new[mnke_pkg::EV_ALT_REL]    = cmd_reg.tap;
        mask_new[mnke_pkg::EV_TAP_SYNC1]  = cmd_reg.tap;
        mask_new[mnke_pkg::EV_KEY_REL]    = release_key;
        mask_new[mnke_pkg::EV_REL_SYNC]   = release_key;
        mask_new[mnke_pkg::EV_MOD_PRESS]  = press_key && has_mod;
        mask_new[mnke_pkg::EV_KEY_PRESS]  = press_key;
        mask_new[mnke_pkg::EV_PRESS_SYNC] = press_key;
        mask_new[mnke_pkg::EV_MOD_REL]    = press_key && has_mod;
        mask_new[mnke_pkg::EV_MOD_SYNC]   = press_key && has_mod;
    end

    // The owner entry is updated once, in the lookup cycle, before the next read.
    assign ram_we    = (state_reg == ST_LOOKUP) && (press_key || release_key);
    assign ram_waddr = cmd_reg.key_code[mnke_pkg::KEY_IDX_W-1:0];
    assign ram_wdata = cmd_reg.on ? cmd_reg.note : '0;

    // The lowest pending slot goes out first.
    always_comb begin
        ev_idx = '0;
        for (int i = mnke_pkg::EVENT_COUNT - 1; i >= 0; i--) begin
            if (mask_reg[i]) begin
                ev_idx = mnke_pkg::ev_idx_t'(i);
            end
        end
    end

    assign mask_rest = mask_reg & (mask_reg - 1'b1);

    always_comb begin
        ev_type  = 1'b1;
        ev_code  = mnke_pkg::KC_NONE;
        ev_value = 1'b0;
        case (ev_idx)
            mnke_pkg::EV_ALT_PRESS: begin
                ev_code  = mnke_pkg::KC_ALT;
                ev_value = 1'b1;
            end
            mnke_pkg::EV_VK_PRESS: begin
                ev_code  = cmd_reg.level_key;
                ev_value = 1'b1;
            end
            mnke_pkg::EV_VK_REL: begin
                ev_code = cmd_reg.level_key;
            end
            mnke_pkg::EV_ALT_REL: begin
                ev_code = mnke_pkg::KC_ALT;
            end
            mnke_pkg::EV_KEY_REL: begin
                ev_code = cmd_reg.key_code;
            end
            mnke_pkg::EV_MOD_PRESS: begin
                ev_code  = mod_key;
                ev_value = 1'b1;
            end
            mnke_pkg::EV_KEY_PRESS: begin
                ev_code  = cmd_reg.key_code;
                ev_value = 1'b1;
            end
            mnke_pkg::EV_MOD_REL: begin
                ev_code = mod_key;
            end
            default: begin
                ev_type = 1'b0;
            end
        endcase
    end

    assign out_load = (state_reg == ST_EMIT) && (!m_valid_reg || m_ready);

    always_comb begin
        state_next = state_reg;
        mask_next  = mask_reg;
        case (state_reg)
            ST_IDLE: begin
                if (pop_valid) begin
                    state_next = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                mask_next  = mask_new;
                state_next = (mask_new != '0) ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT: begin
                if (out_load) begin
                    mask_next = mask_rest;
                    if (mask_rest == '0) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            mask_reg        <= '0;
            owner_valid_reg <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            mask_reg  <= mask_next;
            if (ram_we) begin
                owner_valid_reg[ram_waddr] <= 1'b1;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ram_re) begin
            cmd_reg           <= pop_cmd;
            owner_valid_q_reg <= owner_valid_reg[ram_raddr];
        end
        if (out_load) begin
            m_event_type_reg <= ev_type;
            m_key_code_reg   <= ev_code;
            m_key_value_reg  <= ev_value;
            m_last_reg       <= (mask_rest == '0);
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_event_type = m_event_type_reg;
    assign m_key_code   = m_key_code_reg;
    assign m_key_value  = m_key_value_reg;
    assign m_last       = m_last_reg;

endmodule

// ===== sv/mnke_checker.sv =====
module mnke_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic                            m_event_type,
    input logic [mnke_pkg::KEY_CODE_W-1:0] m_key_code,
    input logic                            m_key_value,
    input logic                            m_last
);

    // After reset the output is empty and the queue takes items.
    a_reset_state: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("output valid or input stalled right after reset");

    // Every item's events end with a sync frame.
    a_last_is_sync: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last |-> !m_event_type)
        else $error("final event of an item is not a sync");

    a_sync_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_event_type |-> (m_key_code == '0) && !m_key_value)
        else $error("sync event carries a code or value");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_event_type) && $stable(m_key_code)
                                && $stable(m_key_value) && $stable(m_last))
        else $error("stalled output item changed");

endmodule

bind midi_note_to_key_events_unit mnke_checker u_checker (.*);

// ===== verif/key_event_checker.sv =====
`timescale 1ns / 100ps

module key_event_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  logic                            s_func,
    input  logic [mnke_pkg::NOTE_W-1:0]     s_note,
    input  logic [mnke_pkg::VEL_W-1:0]      s_velocity,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  logic                            m_event_type,
    input  logic [mnke_pkg::KEY_CODE_W-1:0] m_key_code,
    input  logic                            m_key_value,
    input  logic                            m_last,
    output int                              error_count,
    output int                              pending_events,
    output int                              events_checked
);

    localparam logic [mnke_pkg::KEY_CODE_W-1:0] LEFT_ALT   = 7'd56;
    localparam logic [mnke_pkg::KEY_CODE_W-1:0] LEFT_SHIFT = 7'd42;
    localparam logic [mnke_pkg::KEY_CODE_W-1:0] LEFT_CTRL  = 7'd29;
    localparam int                              MAX_PRINTS = 50;

    typedef struct packed {
        logic                            is_key;
        logic [mnke_pkg::KEY_CODE_W-1:0] code;
        logic                            pressed;
        logic                            last;
    } key_event_t;

    // Keycode and modifier of each note, starting at the lowest note that acts.
    localparam logic [mnke_pkg::KEY_CODE_W-1:0] PIANO_KEY [mnke_pkg::NOTE_COUNT] = '{
        7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,  7'd10, 7'd11,
        7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd2,  7'd2,  7'd3,  7'd3,  7'd4,
        7'd5,  7'd5,  7'd6,  7'd6,  7'd7,  7'd7,  7'd8,  7'd9,  7'd9,  7'd10,
        7'd10, 7'd11, 7'd16, 7'd16, 7'd17, 7'd17, 7'd18, 7'd18, 7'd19, 7'd20,
        7'd20, 7'd21, 7'd21, 7'd22, 7'd23, 7'd23, 7'd24, 7'd24, 7'd25, 7'd25,
        7'd30, 7'd31, 7'd31, 7'd32, 7'd32, 7'd33, 7'd34, 7'd34, 7'd35, 7'd35,
        7'd36, 7'd36, 7'd37, 7'd38, 7'd38, 7'd44, 7'd44, 7'd45, 7'd46, 7'd46,
        7'd47, 7'd47, 7'd48, 7'd48, 7'd49, 7'd50, 7'd21, 7'd22, 7'd23, 7'd24,
        7'd25, 7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36
    };

    localparam mnke_pkg::mod_t PIANO_MOD [mnke_pkg::NOTE_COUNT] = '{
        mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,
        mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,
        mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,
        mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT,
        mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT,
        mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT,
        mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT,
        mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT,
        mnke_pkg::MDF_NONE,  mnke_pkg::MDF_SHIFT, mnke_pkg::MDF_NONE,  mnke_pkg::MDF_NONE,
        mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,
        mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,
        mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL,  mnke_pkg::MDF_CTRL
    };

    localparam logic [mnke_pkg::KEY_CODE_W-1:0] LOUDNESS_KEY [32] = '{
        7'd2,  7'd3,  7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,  7'd10, 7'd11,
        7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
        7'd30, 7'd31, 7'd32, 7'd33, 7'd34, 7'd35, 7'd36, 7'd37, 7'd38,
        7'd44, 7'd45, 7'd46
    };

    logic [mnke_pkg::NOTE_W-1:0]  key_holder [mnke_pkg::KEY_TABLE_DEPTH];
    logic [mnke_pkg::LEVEL_W-1:0] sent_level;
    logic                         level_sent;
    key_event_t                   owed_events [$];

    initial begin
        error_count    = 0;
        pending_events = 0;
        events_checked = 0;
    end

    task automatic report_mismatch(input string what);
        if (error_count < MAX_PRINTS) begin
            $display("[%0t] key event check: %s", $time, what);
        end
        error_count++;
    endtask

    task automatic owe_event(input logic is_key,
                             input logic [mnke_pkg::KEY_CODE_W-1:0] code,
                             input logic pressed);
        key_event_t ev;

        ev          = '{is_key, code, pressed, 1'b0};
        owed_events = {owed_events, ev};
    endtask

    task automatic owe_sync();
        owe_event(1'b0, mnke_pkg::KC_NONE, 1'b0);
    endtask

    task automatic note_to_key_events(input logic on,
                                      input logic [mnke_pkg::NOTE_W-1:0] note_num,
                                      input logic [mnke_pkg::VEL_W-1:0] vel);
        int                              first;
        int                              rom_idx;
        logic [mnke_pkg::KEY_CODE_W-1:0] code;
        logic [mnke_pkg::KEY_CODE_W-1:0] mod_key;
        logic [mnke_pkg::KEY_CODE_W-1:0] level_key;
        logic [mnke_pkg::LEVEL_W-1:0]    level;
        mnke_pkg::mod_t                  modifier;
        key_event_t                      tail;

        first = owed_events.size();
        if (note_num < mnke_pkg::NOTE_LOW || note_num > mnke_pkg::NOTE_HIGH) begin
            return;
        end
        rom_idx  = int'(note_num - mnke_pkg::NOTE_LOW);
        code     = PIANO_KEY[rom_idx];
        modifier = PIANO_MOD[rom_idx];

        if (on) begin
            if (vel != 0) begin
                // A 7-bit velocity divided by four tops out at 31, the highest level.
                level = vel[mnke_pkg::VEL_W-1:2];
                if (!level_sent || level != sent_level) begin
                    level_key  = LOUDNESS_KEY[level];
                    sent_level = level;
                    level_sent = 1'b1;
                    owe_event(1'b1, LEFT_ALT, 1'b1);
                    owe_event(1'b1, level_key, 1'b1);
                    owe_sync();
                    owe_event(1'b1, level_key, 1'b0);
                    owe_event(1'b1, LEFT_ALT, 1'b0);
                    owe_sync();
                end
            end
            if (code < mnke_pkg::KEY_TABLE_DEPTH) begin
                if (key_holder[code] != 0 && key_holder[code] != note_num) begin
                    owe_event(1'b1, code, 1'b0);
                    owe_sync();
                end
                if (modifier != mnke_pkg::MDF_NONE) begin
                    mod_key = (modifier == mnke_pkg::MDF_SHIFT) ? LEFT_SHIFT : LEFT_CTRL;
                    owe_event(1'b1, mod_key, 1'b1);
                    owe_event(1'b1, code, 1'b1);
                    owe_sync();
                    owe_event(1'b1, mod_key, 1'b0);
                    owe_sync();
                end else begin
                    owe_event(1'b1, code, 1'b1);
                    owe_sync();
                end
                key_holder[code] = note_num;
            end
        end else if (code < mnke_pkg::KEY_TABLE_DEPTH && key_holder[code] == note_num) begin
            owe_event(1'b1, code, 1'b0);
            owe_sync();
            key_holder[code] = '0;
        end

        if (owed_events.size() > first) begin
            tail      = owed_events[owed_events.size() - 1];
            tail.last = 1'b1;
            owed_events[owed_events.size() - 1] = tail;
        end
    endtask

    always @(posedge aclk) begin
        key_event_t seen;
        key_event_t owed;

        if (!aresetn) begin
            for (int i = 0; i < mnke_pkg::KEY_TABLE_DEPTH; i++) begin
                key_holder[i] = '0;
            end
            sent_level = '0;
            level_sent = 1'b0;
            owed_events.delete();
        end else begin
            if (s_valid && s_ready) begin
                note_to_key_events(s_func, s_note, s_velocity);
            end
            if (m_valid && m_ready) begin
                seen = '{m_event_type, m_key_code, m_key_value, m_last};
                if (owed_events.size() == 0) begin
                    report_mismatch($sformatf("event %0d arrived with none owed", events_checked));
                end else begin
                    owed = owed_events.pop_front();
                    if (seen.is_key !== owed.is_key) begin
                        report_mismatch($sformatf("event %0d type: want %0d, got %0d",
                                                  events_checked, owed.is_key, seen.is_key));
                    end
                    if (seen.code !== owed.code) begin
                        report_mismatch($sformatf("event %0d code: want %0d, got %0d",
                                                  events_checked, owed.code, seen.code));
                    end
                    if (seen.pressed !== owed.pressed) begin
                        report_mismatch($sformatf("event %0d value: want %0d, got %0d",
                                                  events_checked, owed.pressed, seen.pressed));
                    end
                    if (seen.last !== owed.last) begin
                        report_mismatch($sformatf("event %0d last: want %0d, got %0d",
                                                  events_checked, owed.last, seen.last));
                    end
                end
                events_checked++;
            end
        end
        pending_events = owed_events.size();
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;

    typedef logic [mnke_pkg::NOTE_W-1:0] note_t;
    typedef logic [mnke_pkg::VEL_W-1:0]  vel_t;

    localparam int RANDOM_ITEMS = 87;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 80;
    localparam int CYCLE_LIMIT  = 400000;

    logic                            aclk = 1'b0;
    logic                            aresetn;
    logic                            s_valid;
    logic                            s_ready;
    logic                            s_func;
    note_t                           s_note;
    vel_t                            s_velocity;
    logic                            m_valid;
    logic                            m_ready;
    logic                            m_event_type;
    logic [mnke_pkg::KEY_CODE_W-1:0] m_key_code;
    logic                            m_key_value;
    logic                            m_last;

    int error_count;
    int pending_events;
    int events_checked;
    int cycle_count = 0;
    int notes_on    = 0;
    int notes_off   = 0;
    bit hold_req    = 1'b0;

    note_t held_notes [$];

    midi_note_to_key_events_unit u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_note       (s_note),
        .s_velocity   (s_velocity),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_event_type (m_event_type),
        .m_key_code   (m_key_code),
        .m_key_value  (m_key_value),
        .m_last       (m_last)
    );

    key_event_checker u_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_func         (s_func),
        .s_note         (s_note),
        .s_velocity     (s_velocity),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_event_type   (m_event_type),
        .m_key_code     (m_key_code),
        .m_key_value    (m_key_value),
        .m_last         (m_last),
        .error_count    (error_count),
        .pending_events (pending_events),
        .events_checked (events_checked)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("timeout after %0d cycles", cycle_count);
        $display("tb: errors");
        $finish;
    end

    // Receiver: a rotating stall pattern, reloaded periodically with a new
    // density, plus one long hold-off when the sender asks for it.
    initial begin
        logic [15:0] stall_pattern;
        int          beat;

        m_ready       = 1'b0;
        stall_pattern = 16'hffff;
        beat          = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
            end else begin
                if (beat % 32 == 0) begin
                    case ($urandom_range(0, 3))
                        0: stall_pattern = 16'hffff;
                        1: stall_pattern = 16'($urandom);
                        2: stall_pattern = 16'($urandom | $urandom);
                        default: stall_pattern = 16'($urandom & $urandom);
                    endcase
                end
                m_ready <= stall_pattern[0];
                stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
                beat++;
            end
        end
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic offer_item(input logic on, input note_t note_num, input vel_t vel);
        s_valid    <= 1'b1;
        s_func     <= on;
        s_note     <= note_num;
        s_velocity <= vel;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        if (on) begin
            notes_on++;
        end else begin
            notes_off++;
        end
    endtask

    task automatic idle_sender(input int cycles);
        if (cycles > 0) begin
            s_valid <= 1'b0;
            repeat (cycles) @(negedge aclk);
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (pending_events != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    initial begin
        int    pick;
        int    slot;
        int    burst_left;
        int    random_items;
        bit    hold_done;
        bit    pause_done;
        logic  on;
        note_t note_num;
        vel_t  vel;
        vel_t  prev_vel;

        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_func     = 1'b0;
        s_note     = '0;
        s_velocity = '0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(negedge aclk);

        // Directed: out-of-range notes, off for a note that holds nothing,
        // repeated press, key collisions, both modifiers and level changes.
        offer_item(1'b0, 7'd60, 7'd0);
        offer_item(1'b1, 7'd0, 7'd127);
        offer_item(1'b1, 7'd127, 7'd127);
        offer_item(1'b1, 7'd20, 7'd64);
        offer_item(1'b1, 7'd109, 7'd64);
        offer_item(1'b1, 7'd21, 7'd127);
        offer_item(1'b1, 7'd21, 7'd125);
        offer_item(1'b1, 7'd36, 7'd1);
        offer_item(1'b1, 7'd37, 7'd0);
        offer_item(1'b0, 7'd36, 7'd0);
        offer_item(1'b0, 7'd37, 7'd127);
        offer_item(1'b0, 7'd37, 7'd0);
        offer_item(1'b1, 7'd108, 7'd64);
        offer_item(1'b0, 7'd108, 7'd0);
        offer_item(1'b1, 7'd60, 7'd4);
        offer_item(1'b1, 7'd60, 7'd7);
        offer_item(1'b1, 7'd60, 7'd8);
        offer_item(1'b0, 7'd60, 7'd85);
        offer_item(1'b1, 7'd100, 7'd0);
        offer_item(1'b0, 7'd100, 7'd0);
        offer_item(1'b0, 7'd21, 7'd0);
        offer_item(1'b1, 7'd22, 7'd42);
        offer_item(1'b0, 7'd22, 7'd0);
        wait_drained();

        random_items = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        prev_vel     = 7'd8;
        burst_left   = $urandom_range(1, 12);
        while (random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                on = 1'b1;
                // The low notes share keycodes heavily, so they collide often.
                if ($urandom_range(0, 1)) begin
                    note_num = note_t'($urandom_range(21, 50));
                end else begin
                    note_num = note_t'($urandom_range(21, 108));
                end
                case ($urandom_range(0, 3))
                    0: vel = prev_vel;
                    1: vel = '0;
                    2: vel = vel_t'($urandom_range(0, 127));
                    default: vel = {prev_vel[mnke_pkg::VEL_W-1:2], 2'($urandom_range(0, 3))};
                endcase
                held_notes = {held_notes, note_num};
            end else if (pick < 80 && held_notes.size() > 0) begin
                on       = 1'b0;
                slot     = $urandom_range(0, held_notes.size() - 1);
                note_num = held_notes[slot];
                held_notes.delete(slot);
                vel      = vel_t'($urandom_range(0, 127));
            end else begin
                on       = 1'($urandom_range(0, 1));
                note_num = note_t'($urandom_range(0, 127));
                vel      = vel_t'($urandom_range(0, 127));
            end
            offer_item(on, note_num, vel);
            if (on && vel != 0) begin
                prev_vel = vel;
            end
            random_items++;
            if (random_items == 50 && !hold_done) begin
                hold_req  = 1'b1;
                hold_done = 1'b1;
            end
            if (random_items == 80 && !pause_done) begin
                wait_drained();
                pause_done = 1'b1;
            end
            burst_left--;
            if (burst_left == 0) begin
                idle_sender($urandom_range(0, 10));
                burst_left = $urandom_range(1, 12);
            end
        end

        wait_drained();
        $display("summary: %0d note-on and %0d note-off items sent, %0d key events checked",
                 notes_on, notes_off, events_checked);
        $display("summary: collisions, repeats, level taps and one long output hold-off run");
        if (error_count == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

// ===== midi_note_to_key_events_unit.f =====
sv/mnke_pkg.sv
sv/mnke_ram.sv
sv/mnke_front.sv
sv/mnke_fifo.sv
sv/mnke_back.sv
sv/midi_note_to_key_events_unit.sv
sv/mnke_checker.sv
verif/key_event_checker.sv
verif/tb.sv
